>>> hdl/tccs_pkg.sv
// shared constants, types and helpers for the text console cursor/scroll unit
// no dependencies
`default_nettype none

package tccs_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_STEP   = 8;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // field widths
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;
   localparam int CELL_W = 2 * CHAR_W;

   // character codes and reset values
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
   localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'd15;
   localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;

   // op codes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int QPTR_W     = $clog2(CMDQ_DEPTH);

   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_TAB,
      KIND_NEWLINE,
      KIND_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
      logic              read_hit;
      logic [ADDR_W-1:0] read_addr;
   } cmd_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [CHAR_W-1:0] cell_attr;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_READ_WAIT,
      ST_SCROLL,
      ST_SCROLL_END
   } state_type;

   // cell layout: attribute in the upper byte, character in the lower byte
   function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                   input logic [CHAR_W-1:0] attr);
      return {attr, ch};
   endfunction

endpackage

`default_nettype wire

>>> hdl/tccs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hdl/tccs_front.sv
// front end: input handshake, classification and read address computation
// depends on tccs_pkg
`default_nettype none

module tccs_front (
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_op,
   input  wire logic [tccs_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic [tccs_pkg::ROW_W-1:0]    req_read_row,
   input  wire logic [tccs_pkg::COL_W-1:0]    req_read_column,
   input  wire logic                          queue_full,
   input  wire logic                          clear_busy,
   output logic                               queue_push,
   output tccs_pkg::cmd_type                  cmd
);

   logic row_ok;
   logic col_ok;

   assign req_full   = queue_full | clear_busy;
   assign queue_push = req_push & ~req_full;

   assign row_ok = req_read_row < tccs_pkg::ROW_W'(tccs_pkg::ROWS);
   assign col_ok = (tccs_pkg::COL_W + 1)'(req_read_column) <
                   (tccs_pkg::COL_W + 1)'(tccs_pkg::COLUMNS);

   always_comb begin
      cmd.char_code = req_char_code;
      cmd.read_hit  = row_ok & col_ok;
      cmd.read_addr = tccs_pkg::ADDR_W'(
         tccs_pkg::ADDR_W'(req_read_row) * tccs_pkg::ADDR_W'(tccs_pkg::COLUMNS) +
         tccs_pkg::ADDR_W'(req_read_column));
      if (req_op == tccs_pkg::OP_READ) begin
         cmd.kind = tccs_pkg::KIND_READ;
      end else if (req_char_code == tccs_pkg::CODE_TAB) begin
         cmd.kind = tccs_pkg::KIND_TAB;
      end else if (req_char_code == tccs_pkg::CODE_NEWLINE) begin
         cmd.kind = tccs_pkg::KIND_NEWLINE;
      end else begin
         cmd.kind = tccs_pkg::KIND_CHAR;
      end
   end

endmodule

`default_nettype wire

>>> hdl/tccs_cmd_queue.sv
// short command queue between front and back ends
// depends on tccs_pkg
`default_nettype none

module tccs_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tccs_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output tccs_pkg::cmd_type      head_cmd,
   output logic                   empty
);

   tccs_pkg::cmd_type              entry_ff [tccs_pkg::CMDQ_DEPTH];
   logic [tccs_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tccs_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tccs_pkg::QPTR_W:0]      count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;

   assign full     = count_ff == (tccs_pkg::QPTR_W + 1)'(tccs_pkg::CMDQ_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   function automatic logic [tccs_pkg::QPTR_W-1:0] ptr_next(
      input logic [tccs_pkg::QPTR_W-1:0] p);
      if (p == tccs_pkg::QPTR_W'(tccs_pkg::CMDQ_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (tccs_pkg::QPTR_W + 1)'(do_push)
                           - (tccs_pkg::QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> hdl/tccs_back.sv
// back end: cursor, screen store sequencing (clear, put, read, scroll), result word
// depends on tccs_pkg and tccs_ram
`default_nettype none

module tccs_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [tccs_pkg::CHAR_W-1:0]   csr_write_data,
   input  wire tccs_pkg::cmd_type             head_cmd,
   input  wire logic                          queue_empty,
   output logic                               queue_pop,
   output logic                               clear_busy,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output tccs_pkg::rsp_data_type             rsp_data
);

   localparam logic [tccs_pkg::ADDR_W-1:0] LAST_ADDR = tccs_pkg::ADDR_W'(tccs_pkg::CELL_COUNT - 1);

   tccs_pkg::state_type              state_ff, state_in;
   logic [tccs_pkg::ADDR_W-1:0]      cnt_ff, cnt_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [tccs_pkg::ADDR_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [tccs_pkg::COL_W-1:0]       cur_col_ff, cur_col_in;
   logic [tccs_pkg::ROW_W-1:0]       cur_row_ff, cur_row_in;
   logic [tccs_pkg::CHAR_W-1:0]      attr_ff, attr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   tccs_pkg::rsp_data_type           rsp_ff, rsp_in;

   logic                             out_free;
   logic                             take;
   logic                             is_read;
   logic                             read_hit;
   logic                             wrap;
   logic [tccs_pkg::COL_W:0]         col_step;
   logic [tccs_pkg::COL_W:0]         col_sum;
   logic [tccs_pkg::COL_W-1:0]       col_nx;
   logic                             row_inc;
   logic [tccs_pkg::ROW_W:0]         row_sum;
   logic [tccs_pkg::ROW_W-1:0]       row_nx;
   logic [tccs_pkg::ADDR_W-1:0]      cur_addr;

   logic                             ram_wr_en;
   logic [tccs_pkg::ADDR_W-1:0]      ram_wr_addr;
   logic [tccs_pkg::CELL_W-1:0]      ram_wr_data;
   logic [tccs_pkg::ADDR_W-1:0]      ram_rd_addr;
   logic [tccs_pkg::CELL_W-1:0]      ram_rd_data;

   tccs_ram #(
      .WIDTH (tccs_pkg::CELL_W),
      .DEPTH (tccs_pkg::CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free   = ~rsp_valid_ff | rsp_pop;
   assign take       = (state_ff == tccs_pkg::ST_RUN) & out_free & ~queue_empty;
   assign queue_pop  = take;
   assign is_read    = head_cmd.kind == tccs_pkg::KIND_READ;
   assign read_hit   = head_cmd.read_hit;
   assign clear_busy = state_ff == tccs_pkg::ST_CLEAR;
   assign rsp_empty  = ~rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign cur_addr   = tccs_pkg::ADDR_W'(
      tccs_pkg::ADDR_W'(cur_row_ff) * tccs_pkg::ADDR_W'(tccs_pkg::COLUMNS) +
      tccs_pkg::ADDR_W'(cur_col_ff));

   // cursor advance for a put
   always_comb begin
      case (head_cmd.kind)
         tccs_pkg::KIND_CHAR: col_step = (tccs_pkg::COL_W + 1)'(1);
         tccs_pkg::KIND_TAB:  col_step = (tccs_pkg::COL_W + 1)'(tccs_pkg::TAB_STEP);
         default:             col_step = '0;
      endcase
      col_sum = (tccs_pkg::COL_W + 1)'(cur_col_ff) + col_step;
      if (head_cmd.kind == tccs_pkg::KIND_NEWLINE ||
          col_sum >= (tccs_pkg::COL_W + 1)'(tccs_pkg::COLUMNS)) begin
         col_nx  = '0;
         row_inc = 1'b1;
      end else begin
         col_nx  = col_sum[tccs_pkg::COL_W-1:0];
         row_inc = 1'b0;
      end
      row_sum = (tccs_pkg::ROW_W + 1)'(cur_row_ff) + (tccs_pkg::ROW_W + 1)'(row_inc);
      wrap    = row_sum >= (tccs_pkg::ROW_W + 1)'(tccs_pkg::ROWS);
      row_nx  = wrap ? tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1) : row_sum[tccs_pkg::ROW_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tccs_pkg::ST_CLEAR: begin
            if (cnt_ff == LAST_ADDR) begin
               state_in = tccs_pkg::ST_RUN;
            end
         end
         tccs_pkg::ST_RUN: begin
            if (take) begin
               if (is_read) begin
                  if (read_hit) begin
                     state_in = tccs_pkg::ST_READ_WAIT;
                  end
               end else if (wrap) begin
                  state_in = tccs_pkg::ST_SCROLL;
               end
            end
         end
         tccs_pkg::ST_READ_WAIT:  state_in = tccs_pkg::ST_RUN;
         tccs_pkg::ST_SCROLL: begin
            if (cnt_ff == LAST_ADDR) begin
               state_in = tccs_pkg::ST_SCROLL_END;
            end
         end
         tccs_pkg::ST_SCROLL_END: state_in = tccs_pkg::ST_RUN;
         default:                 state_in = tccs_pkg::ST_RUN;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in        = cnt_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = cnt_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      attr_in       = csr_write_enable ? csr_write_data : attr_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_pop;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pend_addr_ff;
      ram_wr_data   = tccs_pkg::make_cell(head_cmd.char_code, attr_ff);
      ram_rd_addr   = head_cmd.read_addr;

      case (state_ff)
         tccs_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = tccs_pkg::make_cell(tccs_pkg::BLANK_CHAR, tccs_pkg::RESET_ATTR);
            cnt_in      = (cnt_ff == LAST_ADDR) ? '0 : cnt_ff + 1'b1;
         end
         tccs_pkg::ST_RUN: begin
            if (take) begin
               if (is_read) begin
                  if (!read_hit) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.cell_char  = '0;
                     rsp_in.cell_attr  = '0;
                     rsp_in.cursor_col = cur_col_ff;
                     rsp_in.cursor_row = cur_row_ff;
                     rsp_in.scrolled   = 1'b0;
                  end
               end else begin
                  // cursor is always on screen, so a character write never misses
                  ram_wr_en   = head_cmd.kind == tccs_pkg::KIND_CHAR;
                  ram_wr_addr = cur_addr;
                  cur_col_in  = col_nx;
                  cur_row_in  = row_nx;
                  if (!wrap) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.cell_char  = '0;
                     rsp_in.cell_attr  = '0;
                     rsp_in.cursor_col = col_nx;
                     rsp_in.cursor_row = row_nx;
                     rsp_in.scrolled   = 1'b0;
                  end
               end
            end
         end
         tccs_pkg::ST_READ_WAIT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.cell_char  = ram_rd_data[tccs_pkg::CHAR_W-1:0];
            rsp_in.cell_attr  = ram_rd_data[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
            rsp_in.cursor_col = cur_col_ff;
            rsp_in.cursor_row = cur_row_ff;
            rsp_in.scrolled   = 1'b0;
         end
         tccs_pkg::ST_SCROLL, tccs_pkg::ST_SCROLL_END: begin
            // read one row ahead, write the cell fetched last cycle one row up
            ram_rd_addr   = tccs_pkg::ADDR_W'(cnt_ff + tccs_pkg::ADDR_W'(tccs_pkg::COLUMNS));
            ram_wr_en     = pend_valid_ff;
            ram_wr_addr   = pend_addr_ff;
            ram_wr_data   = (pend_addr_ff < tccs_pkg::ADDR_W'(tccs_pkg::COPY_COUNT)) ?
                            ram_rd_data :
                            tccs_pkg::make_cell(tccs_pkg::BLANK_CHAR, attr_ff);
            if (state_ff == tccs_pkg::ST_SCROLL) begin
               pend_valid_in = 1'b1;
               cnt_in        = (cnt_ff == LAST_ADDR) ? '0 : cnt_ff + 1'b1;
            end else begin
               rsp_valid_in      = 1'b1;
               rsp_in.cell_char  = '0;
               rsp_in.cell_attr  = '0;
               rsp_in.cursor_col = cur_col_ff;
               rsp_in.cursor_row = cur_row_ff;
               rsp_in.scrolled   = 1'b1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tccs_pkg::ST_CLEAR;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         attr_ff       <= tccs_pkg::RESET_ATTR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         attr_ff       <= attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

>>> hdl/text_console_cursor_scroll_unit.sv
// Text console cursor/scroll unit: an 80x25 character-cell screen store with
// a cursor. A put word writes a character at the cursor (tab and newline only
// move the cursor) and scrolls the screen up when the cursor runs off the last
// row; a read word returns one cell. Every input word yields one result word.
// After reset the unit runs a clearing pass (one cell per cycle) that fills
// the screen with blanks of attribute 15; req_full stays high throughout,
// while csr writes are taken as usual. The single write port and registered
// read port of the screen ram set the sequencing: a non-scrolling put and an
// out-of-range read post their result when taken, a read that hits the
// screen waits in ST_READ_WAIT for the registered read data, and a scrolling
// put moves one cell per cycle in ST_SCROLL, then writes the last cell and
// posts the result in ST_SCROLL_END. Input words wait in a two-word queue and
// the result word sits in an output register, so while a result waits for
// pop the input side still takes up to two more words before req_full rises.
// depends on tccs_pkg, tccs_front, tccs_cmd_queue, tccs_back, tccs_ram
`default_nettype none

module text_console_cursor_scroll_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,

   // configuration: attribute byte for written characters and scroll blanks
   input  wire logic                          csr_write_enable,
   input  wire logic [tccs_pkg::CHAR_W-1:0]   csr_write_data,

   // input word channel
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_op,
   input  wire logic [tccs_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic [tccs_pkg::ROW_W-1:0]    req_read_row,
   input  wire logic [tccs_pkg::COL_W-1:0]    req_read_column,

   // result word channel
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [tccs_pkg::CHAR_W-1:0]        rsp_cell_char,
   output logic [tccs_pkg::CHAR_W-1:0]        rsp_cell_attr,
   output logic [tccs_pkg::COL_W-1:0]         rsp_cursor_col_out,
   output logic [tccs_pkg::ROW_W-1:0]         rsp_cursor_row_out,
   output logic                               rsp_scrolled
);

   tccs_pkg::cmd_type       front_cmd;
   tccs_pkg::cmd_type       head_cmd;
   tccs_pkg::rsp_data_type  rsp_data;
   logic                    queue_push;
   logic                    queue_full;
   logic                    queue_pop;
   logic                    queue_empty;
   logic                    clear_busy;

   // front end: classify the word and precompute the read address
   tccs_front u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_char_code   (req_char_code),
      .req_read_row    (req_read_row),
      .req_read_column (req_read_column),
      .queue_full      (queue_full),
      .clear_busy      (clear_busy),
      .queue_push      (queue_push),
      .cmd             (front_cmd)
   );

   // decouples the front end from a long scroll in the back end
   tccs_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   // back end: cursor, screen ram and result register
   tccs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_cmd         (head_cmd),
      .queue_empty      (queue_empty),
      .queue_pop        (queue_pop),
      .clear_busy       (clear_busy),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data)
   );

   // result word fields
   assign rsp_cell_char      = rsp_data.cell_char;
   assign rsp_cell_attr      = rsp_data.cell_attr;
   assign rsp_cursor_col_out = rsp_data.cursor_col;
   assign rsp_cursor_row_out = rsp_data.cursor_row;
   assign rsp_scrolled       = rsp_data.scrolled;

endmodule

`default_nettype wire
